@@ hw/rtl/ppv_pkg.sv @@
// Shared constants and register codes for the vertex projection block.
package ppv_pkg;

    // Default number formats
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    // Viewport size registers are 13 bits wide
    localparam int VP_W = 13;

    // Configuration index width
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_SCALE       = 3'd0,
        REG_Y_SCALE       = 3'd1,
        REG_Z_SCALE       = 3'd2,
        REG_Z_OFFSET      = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5
    } t_reg_idx;

    // Reset values (Q16.16 for the coefficients)
    localparam int X_SCALE_RST  = 85134;
    localparam int Y_SCALE_RST  = 113512;
    localparam int Z_SCALE_RST  = -66195;
    localparam int Z_OFFSET_RST = -65864;
    localparam int WIDTH_RST    = 800;
    localparam int HEIGHT_RST   = 600;

endpackage

@@ hw/rtl/ppv_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, magnitude in and out.
module ppv_divider #(
    parameter int COORD_WIDTH = ppv_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ppv_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_neg,
    input  logic [COORD_WIDTH-1:0] i_num,
    input  logic [COORD_WIDTH-1:0] i_den,
    output logic                   o_valid,
    output logic                   o_neg,
    output logic [COORD_WIDTH-1:0] o_quot
);

    localparam int W = COORD_WIDTH;
    localparam int N = COORD_WIDTH + FRAC_BITS;

    // Per-stage registers
    logic         r_vld  [N];
    logic         r_neg  [N];
    logic [W-1:0] r_rem  [N];
    logic [W-1:0] r_den  [N];
    logic [N-1:0] r_dvd  [N];
    logic [N-1:0] r_quot [N];

    genvar s;
    generate
        for (s = 0; s < N; s++) begin : g_stage
            logic         p_vld;
            logic         p_neg;
            logic [W-1:0] p_rem;
            logic [W-1:0] p_den;
            logic [N-1:0] p_dvd;
            logic [N-1:0] p_quot;
            logic [W:0]   n_trial;
            logic         n_ge;

            if (s == 0) begin : g_first
                assign p_vld  = i_valid;
                assign p_neg  = i_neg;
                assign p_rem  = '0;
                assign p_den  = i_den;
                assign p_dvd  = {i_num, {FRAC_BITS{1'b0}}};
                assign p_quot = '0;
            end else begin : g_next
                assign p_vld  = r_vld[s-1];
                assign p_neg  = r_neg[s-1];
                assign p_rem  = r_rem[s-1];
                assign p_den  = r_den[s-1];
                assign p_dvd  = r_dvd[s-1];
                assign p_quot = r_quot[s-1];
            end

            // Bring down the next dividend bit and try a subtract
            assign n_trial = {p_rem, p_dvd[N-1]};
            assign n_ge    = (n_trial >= {1'b0, p_den});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                r_neg[s]  <= p_neg;
                r_den[s]  <= p_den;
                r_dvd[s]  <= {p_dvd[N-2:0], 1'b0};
                r_quot[s] <= {p_quot[N-2:0], n_ge};
                r_rem[s]  <= n_ge ? W'(n_trial - {1'b0, p_den}) : W'(n_trial);
            end
        end
    endgenerate

    // Cap the magnitude at 2^(W-1)
    localparam logic [N-1:0] CAP = N'(1) << (W - 1);

    assign o_valid = r_vld[N-1];
    assign o_neg   = r_neg[N-1];
    assign o_quot  = (r_quot[N-1] > CAP) ? W'(CAP) : r_quot[N-1][W-1:0];

endmodule

@@ hw/rtl/perspective_project_vertex.sv @@
// Top level of the vertex projection and viewport pipeline.
//
// Usage: raise start with a vertex on i_pos_x/y/z; the word is taken at any
// rising edge with start high and busy low. busy is low whenever the block is
// out of reset, so one vertex can enter every cycle.
// Each vertex gives one result word on o_screen_x, o_screen_y, o_depth_ndc,
// o_clip_w and o_divide_error, flagged by o_valid for exactly one cycle.
// Vertices pass stages A to C (Q16.16 multiply, saturate), the dividers at one
// quotient bit per cycle, then stages E to G (viewport scaling). Throughput is
// one vertex per cycle. The receiver cannot hold results off, so the pipeline
// never stalls. Coefficients and viewport size are written over the cfg channel
// (always ready); the user must write them only while no vertex is in flight,
// which the block does not enforce. Reset loads the default projection and an
// 800x600 viewport and empties the pipeline; busy is high in reset.
module perspective_project_vertex #(
    parameter int FRAC_BITS   = ppv_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = ppv_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]  i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]  i_pos_z,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ppv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_WIDTH-1:0]         i_cfg_data,
    // result channel
    output logic                           o_valid,
    output logic signed [COORD_WIDTH-1:0]  o_screen_x,
    output logic signed [COORD_WIDTH-1:0]  o_screen_y,
    output logic signed [COORD_WIDTH-1:0]  o_depth_ndc,
    output logic signed [COORD_WIDTH-1:0]  o_clip_w,
    output logic                           o_divide_error
);

    localparam int W   = COORD_WIDTH;
    localparam int PW  = 2 * W;
    localparam int SW  = 2 * W + 2;
    localparam int VPW = ppv_pkg::VP_W;
    localparam int MW  = W + VPW + 2;
    localparam int N   = W + FRAC_BITS;

    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W:0]   ONE_Q = (W+1)'(1) <<< FRAC_BITS;

    // Saturate a wide signed value to W bits
    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
        logic ovf;
        ovf = !((&v[SW-1:W-1]) || !(|v[SW-1:W-1]));
        if (ovf) begin
            sat_w = v[SW-1] ? CMIN : CMAX;
        end else begin
            sat_w = v[W-1:0];
        end
    endfunction

    // Signed value from a capped magnitude
    function automatic logic signed [W-1:0] from_mag(input logic neg, input logic [W-1:0] m);
        if (neg) begin
            from_mag = -$signed(m);
        end else begin
            from_mag = m[W-1] ? CMAX : $signed(m);
        end
    endfunction

    // Configuration registers
    logic signed [W-1:0] r_x_scale, r_y_scale, r_z_scale, r_z_offset;
    logic [VPW-1:0]      r_width, r_height;

    assign o_cfg_ready = 1'b1;
    assign busy        = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale  <= W'(ppv_pkg::X_SCALE_RST);
            r_y_scale  <= W'(ppv_pkg::Y_SCALE_RST);
            r_z_scale  <= W'(ppv_pkg::Z_SCALE_RST);
            r_z_offset <= W'(ppv_pkg::Z_OFFSET_RST);
            r_width    <= VPW'(ppv_pkg::WIDTH_RST);
            r_height   <= VPW'(ppv_pkg::HEIGHT_RST);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppv_pkg::REG_X_SCALE:       r_x_scale  <= i_cfg_data;
                ppv_pkg::REG_Y_SCALE:       r_y_scale  <= i_cfg_data;
                ppv_pkg::REG_Z_SCALE:       r_z_scale  <= i_cfg_data;
                ppv_pkg::REG_Z_OFFSET:      r_z_offset <= i_cfg_data;
                ppv_pkg::REG_SCREEN_WIDTH:  r_width    <= i_cfg_data[VPW-1:0];
                ppv_pkg::REG_SCREEN_HEIGHT: r_height   <= i_cfg_data[VPW-1:0];
                default: ;
            endcase
        end
    end

    logic n_accept;
    assign n_accept = start && !busy;

    // Stage A: full-precision products, clip w
    logic                 r_a_vld, r_a_err;
    logic signed [PW-1:0] r_a_px, r_a_py, r_a_pz;
    logic signed [W-1:0]  r_a_cw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= n_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_px  <= r_x_scale * i_pos_x;
        r_a_py  <= r_y_scale * i_pos_y;
        r_a_pz  <= r_z_scale * i_pos_z;
        r_a_cw  <= (i_pos_z == CMIN) ? CMAX : -i_pos_z;
        r_a_err <= (i_pos_z == '0);
    end

    // Stage B: drop fraction bits, saturate, add depth offset
    logic                 r_b_vld, r_b_err;
    logic signed [W-1:0]  r_b_cx, r_b_cy, r_b_cz, r_b_cw;
    logic signed [PW-1:0] n_shx, n_shy, n_shz;
    logic signed [W-1:0]  n_czp;

    assign n_shx = r_a_px >>> FRAC_BITS;
    assign n_shy = r_a_py >>> FRAC_BITS;
    assign n_shz = r_a_pz >>> FRAC_BITS;
    assign n_czp = sat_w(SW'(n_shz));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_cx  <= sat_w(SW'(n_shx));
        r_b_cy  <= sat_w(SW'(n_shy));
        r_b_cz  <= sat_w(SW'(n_czp) + SW'(r_z_offset));
        r_b_cw  <= r_a_cw;
        r_b_err <= r_a_err;
    end

    // Stage C: signs and magnitudes for the dividers
    logic         r_c_vld, r_c_err;
    logic         r_c_nx, r_c_ny, r_c_nz;
    logic [W-1:0] r_c_mx, r_c_my, r_c_mz, r_c_mw;
    logic signed [W-1:0] r_c_cw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_nx  <= r_b_cx[W-1] ^ r_b_cw[W-1];
        r_c_ny  <= r_b_cy[W-1] ^ r_b_cw[W-1];
        r_c_nz  <= r_b_cz[W-1] ^ r_b_cw[W-1];
        r_c_mx  <= r_b_cx[W-1] ? W'(-r_b_cx) : W'(r_b_cx);
        r_c_my  <= r_b_cy[W-1] ? W'(-r_b_cy) : W'(r_b_cy);
        r_c_mz  <= r_b_cz[W-1] ? W'(-r_b_cz) : W'(r_b_cz);
        r_c_mw  <= r_b_cw[W-1] ? W'(-r_b_cw) : W'(r_b_cw);
        r_c_cw  <= r_b_cw;
        r_c_err <= r_b_err;
    end

    // Dividers
    logic         d_x_vld, d_y_vld, d_z_vld;
    logic         d_x_neg, d_y_neg, d_z_neg;
    logic [W-1:0] d_x_q, d_y_q, d_z_q;

    ppv_divider #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_c_vld), .i_neg(r_c_nx),
        .i_num(r_c_mx), .i_den(r_c_mw),
        .o_valid(d_x_vld), .o_neg(d_x_neg), .o_quot(d_x_q)
    );

    ppv_divider #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_c_vld), .i_neg(r_c_ny),
        .i_num(r_c_my), .i_den(r_c_mw),
        .o_valid(d_y_vld), .o_neg(d_y_neg), .o_quot(d_y_q)
    );

    ppv_divider #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_c_vld), .i_neg(r_c_nz),
        .i_num(r_c_mz), .i_den(r_c_mw),
        .o_valid(d_z_vld), .o_neg(d_z_neg), .o_quot(d_z_q)
    );

    // Clip w and error flag ride alongside the dividers
    logic signed [W-1:0] r_cw_dly  [N];
    logic                r_err_dly [N];

    always_ff @(posedge i_clk) begin
        r_cw_dly[0]  <= r_c_cw;
        r_err_dly[0] <= r_c_err;
        for (int k = 1; k < N; k++) begin
            r_cw_dly[k]  <= r_cw_dly[k-1];
            r_err_dly[k] <= r_err_dly[k-1];
        end
    end

    // Stage E: signed ratios, offset by one
    logic                r_e_vld, r_e_err;
    logic signed [W:0]   r_e_ax, r_e_ay;
    logic signed [W-1:0] r_e_dz, r_e_cw;
    logic signed [W-1:0] n_qx, n_qy;

    assign n_qx = from_mag(d_x_neg, d_x_q);
    assign n_qy = from_mag(d_y_neg, d_y_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= d_x_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_ax  <= (W+1)'(n_qx) + ONE_Q;
        r_e_ay  <= ONE_Q - (W+1)'(n_qy);
        r_e_dz  <= from_mag(d_z_neg, d_z_q);
        r_e_cw  <= r_cw_dly[N-1];
        r_e_err <= r_err_dly[N-1];
    end

    // Stage F: scale by viewport size
    logic                r_f_vld, r_f_err;
    logic signed [MW-1:0] r_f_sx, r_f_sy;
    logic signed [W-1:0] r_f_dz, r_f_cw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_sx  <= r_e_ax * $signed({1'b0, r_width});
        r_f_sy  <= r_e_ay * $signed({1'b0, r_height});
        r_f_dz  <= r_e_dz;
        r_f_cw  <= r_e_cw;
        r_f_err <= r_e_err;
    end

    // Stage G: halve with floor, saturate, force zero on error
    logic                 r_g_vld, r_g_err;
    logic signed [W-1:0]  r_g_sx, r_g_sy, r_g_dz, r_g_cw;
    logic signed [MW-1:0] n_hx, n_hy;

    assign n_hx = r_f_sx >>> 1;
    assign n_hy = r_f_sy >>> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_err <= r_f_err;
        if (r_f_err) begin
            r_g_sx <= '0;
            r_g_sy <= '0;
            r_g_dz <= '0;
            r_g_cw <= '0;
        end else begin
            r_g_sx <= sat_w(SW'(n_hx));
            r_g_sy <= sat_w(SW'(n_hy));
            r_g_dz <= r_f_dz;
            r_g_cw <= r_f_cw;
        end
    end

    assign o_valid        = r_g_vld;
    assign o_screen_x     = r_g_sx;
    assign o_screen_y     = r_g_sy;
    assign o_depth_ndc    = r_g_dz;
    assign o_clip_w       = r_g_cw;
    assign o_divide_error = r_g_err;

    // Checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |->
            o_screen_x == '0 && o_screen_y == '0 && o_depth_ndc == '0 && o_clip_w == '0)
        else $error("error word with nonzero fields");

    a_cw_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_divide_error |-> o_clip_w != '0)
        else $error("zero clip w without error flag");

    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_x_vld == d_y_vld && d_x_vld == d_z_vld)
        else $error("dividers out of step");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_vld |=> o_valid)
        else $error("word lost in last stage");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the perspective projection and viewport block.
`timescale 1ns / 1ps

module tb_top;

    localparam int  FRAC  = ppv_pkg::FRAC_BITS_DEF;
    localparam int  CW    = ppv_pkg::COORD_WIDTH_DEF;
    localparam int  IW    = ppv_pkg::CFG_IDX_W;
    localparam longint ONE_Q  = longint'(1) << FRAC;
    localparam longint MAX_Q  = 64'sd2147483647;
    localparam longint MIN_Q  = -64'sd2147483648;
    localparam int  DRAIN_CYCLES = CW + ppv_pkg::FRAC_BITS_DEF + 20;
    // indexes that decode to no register
    localparam logic [IW-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [IW-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] dz;
        logic signed [CW-1:0] cw;
        logic                 err;
    } t_proj;

    typedef struct {
        int    px, py, pz;
        bit    typed;
        t_proj res;
    } t_vec_row;

    logic                 i_clk, i_rst_n, start, busy;
    logic signed [CW-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic                 i_cfg_valid, o_cfg_ready;
    logic [IW-1:0]        i_cfg_index;
    logic [CW-1:0]        i_cfg_data;
    logic                 o_valid, o_divide_error;
    logic signed [CW-1:0] o_screen_x, o_screen_y, o_depth_ndc, o_clip_w;

    perspective_project_vertex u_top (.*);

    // Shadow copy of the projection registers
    longint      xs_q, ys_q, zs_q, zo_q;
    logic [12:0] vp_w, vp_h;

    t_proj pending_q[$];
    bit    failed;
    bit    burst;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint clamp_q(longint v);
        if (v > MAX_Q) return MAX_Q;
        if (v < MIN_Q) return MIN_Q;
        return v;
    endfunction

    // Fixed-point projection of one vertex with the current register set
    function automatic t_proj project(int px, int py, int pz);
        t_proj  r;
        longint w, cx, cy, cz, qx, qy;
        r = '0;
        w = clamp_q(-longint'(pz));
        if (w == 0) begin
            r.err = 1'b1;
            return r;
        end
        cx = clamp_q((xs_q * longint'(px)) >>> FRAC);
        cy = clamp_q((ys_q * longint'(py)) >>> FRAC);
        cz = clamp_q(clamp_q((zs_q * longint'(pz)) >>> FRAC) + zo_q);
        qx = clamp_q((cx <<< FRAC) / w);
        qy = clamp_q((cy <<< FRAC) / w);
        r.dz = CW'(clamp_q((cz <<< FRAC) / w));
        r.sx = CW'(clamp_q(((qx + ONE_Q) * longint'(vp_w)) >>> 1));
        r.sy = CW'(clamp_q(((ONE_Q - qy) * longint'(vp_h)) >>> 1));
        r.cw = CW'(w);
        return r;
    endfunction

    // Result checker: each strobed word against the oldest prediction
    always @(posedge i_clk) begin
        t_proj e;
        if (o_valid) begin
            if (pending_q.size() == 0) begin
                $error("result word with nothing expected");
                failed = 1'b1;
            end else begin
                e = pending_q.pop_front();
                if (o_screen_x !== e.sx) begin
                    $error("screen_x exp %0d got %0d", e.sx, o_screen_x); failed = 1'b1;
                end
                if (o_screen_y !== e.sy) begin
                    $error("screen_y exp %0d got %0d", e.sy, o_screen_y); failed = 1'b1;
                end
                if (o_depth_ndc !== e.dz) begin
                    $error("depth_ndc exp %0d got %0d", e.dz, o_depth_ndc); failed = 1'b1;
                end
                if (o_clip_w !== e.cw) begin
                    $error("clip_w exp %0d got %0d", e.cw, o_clip_w); failed = 1'b1;
                end
                if (o_divide_error !== e.err) begin
                    $error("divide_error exp %0b got %0b", e.err, o_divide_error);
                    failed = 1'b1;
                end
            end
        end
    end

    // Present one vertex after a random gap; returns once the word is taken
    task automatic send_vertex(int px, int py, int pz, bit typed, t_proj res);
        int gap;
        if ($urandom_range(0, 31) == 0) burst = ~burst;
        gap = burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_q.push_back(typed ? res : project(px, py, pz));
    endtask

    // Let every result out, then allow the pipeline to empty fully
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; valid stays high so writes can follow back to back
    task automatic cfg_write(logic [IW-1:0] idx, logic [CW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            ppv_pkg::REG_X_SCALE:       xs_q = longint'(signed'(data));
            ppv_pkg::REG_Y_SCALE:       ys_q = longint'(signed'(data));
            ppv_pkg::REG_Z_SCALE:       zs_q = longint'(signed'(data));
            ppv_pkg::REG_Z_OFFSET:      zo_q = longint'(signed'(data));
            ppv_pkg::REG_SCREEN_WIDTH:  vp_w = data[12:0];
            ppv_pkg::REG_SCREEN_HEIGHT: vp_h = data[12:0];
            default: ;
        endcase
    endtask

    // Close a run of register writes
    task automatic cfg_done;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic cfg_all(int xs, int ys, int zs, int zo, int w, int h);
        cfg_write(ppv_pkg::REG_X_SCALE, xs);
        cfg_write(ppv_pkg::REG_Y_SCALE, ys);
        cfg_write(ppv_pkg::REG_Z_SCALE, zs);
        cfg_write(ppv_pkg::REG_Z_OFFSET, zo);
        cfg_write(ppv_pkg::REG_SCREEN_WIDTH, w);
        cfg_write(ppv_pkg::REG_SCREEN_HEIGHT, h);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 1;
            3: return -1;
            4: return 0;
            default: return 65536;
        endcase
    endfunction

    // Mostly plausible scene vertices, plus raw words, extremes and zero depth
    task automatic random_vertices(int count);
        int    px, py, pz;
        t_proj none;
        none = '0;
        repeat (count) begin
            case ($urandom_range(0, 7))
                0: begin
                    px = $urandom; py = $urandom; pz = $urandom;
                end
                1: begin
                    px = pick_extreme(); py = pick_extreme(); pz = pick_extreme();
                end
                2: begin
                    px = $urandom; py = $urandom; pz = 0;
                end
                3: begin
                    px = $urandom_range(0, 1048575) - 524288;
                    py = $urandom_range(0, 1048575) - 524288;
                    pz = $urandom_range(0, 1048575) - 524288;
                end
                default: begin
                    px = $urandom_range(0, 2097151) - 1048576;
                    py = $urandom_range(0, 2097151) - 1048576;
                    pz = -$urandom_range(6554, 6553600);
                end
            endcase
            send_vertex(px, py, pz, 1'b0, none);
        end
    endtask

    initial begin
        t_vec_row dir_tab[$];
        t_vec_row row;

        i_rst_n = 1'b0; start = 1'b0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        failed = 1'b0; burst = 1'b0;
        xs_q = ppv_pkg::X_SCALE_RST; ys_q = ppv_pkg::Y_SCALE_RST;
        zs_q = ppv_pkg::Z_SCALE_RST; zo_q = ppv_pkg::Z_OFFSET_RST;
        vp_w = ppv_pkg::WIDTH_RST;   vp_h = ppv_pkg::HEIGHT_RST;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at reset settings; typed rows are read straight off the spec
        dir_tab = '{
            '{0, 0, -65536, 1'b1, '{26214400, 19660800, 331, 65536, 1'b0}},
            '{0, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b1}},
            '{32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1, '{0, 0, 0, 0, 1'b1}},
            '{32'h8000_0000, 32'h7FFF_FFFF, 0, 1'b1, '{0, 0, 0, 0, 1'b1}},
            '{0, 0, 32'h8000_0000, 1'b0, '0},
            '{0, 0, 32'h7FFF_FFFF, 1'b0, '0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, -1, 1'b0, '0},
            '{32'h8000_0000, 32'h8000_0000, -1, 1'b0, '0},
            '{32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b0, '0},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
            '{65536, -65536, -131072, 1'b0, '0},
            '{-1, 1, -65536, 1'b0, '0},
            '{-32'sd655360, 655360, -655360, 1'b0, '0},
            '{123456, -98765, 65536, 1'b0, '0},
            '{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0}
        };
        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            send_vertex(row.px, row.py, row.pz, row.typed, row.res);
        end
        random_vertices(250);
        drain;

        // Largest coefficients, 4096x4096 viewport
        cfg_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4096, 4096);
        cfg_done;
        random_vertices(230);
        drain;

        // Most negative coefficients, one-pixel viewport
        cfg_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1);
        cfg_done;
        random_vertices(230);
        drain;

        // Zero and 8191 viewport sizes, width kept to its low 13 bits; spare indexes ignored
        cfg_all(65536, -65536, 65536, 0, 0, 8191);
        cfg_write(REG_SPARE_6, $urandom);
        cfg_write(REG_SPARE_7, $urandom);
        cfg_write(ppv_pkg::REG_SCREEN_WIDTH, 32'hFFFF_E000 | 13'd4097);
        cfg_done;
        random_vertices(230);
        drain;

        // A few plausible projections, then fully random register words
        repeat (2) begin
            cfg_all($urandom_range(32768, 262144), $urandom_range(32768, 262144),
                    -$urandom_range(65536, 131072), -$urandom_range(0, 1310720),
                    $urandom_range(1, 4096), $urandom_range(1, 4096));
            cfg_done;
            random_vertices(230);
            drain;
        end
        repeat (2) begin
            cfg_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            cfg_done;
            random_vertices(230);
            drain;
        end

        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
